// ----- design/kmes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmes_pkg: shared types and constants of the key matrix event scanner
// Command and register codes, event and result layouts, defaults.
// ----------------------------------------------------------------------------
package kmes_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int ROW_COUNT_DEF   = 15;

  localparam int MATRIX_BITS = 120;  // matrix_low plus matrix_high
  localparam int KEY_W       = 7;
  localparam int DELAY_W     = 15;
  localparam int CNT_W       = 16;
  localparam int QCOUNT_W    = 5;
  localparam int IN_DATA_W   = 128;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_DATA_W  = 64;

  localparam logic [KEY_W-1:0]   NO_KEY         = 7'd127;
  localparam int                 SHIFT_CODE     = 112;
  localparam int                 CTRL_CODE      = 113;
  localparam logic [DELAY_W-1:0] DEFAULT_DELAY  = 15'd12;
  localparam logic [DELAY_W-1:0] DEFAULT_PERIOD = 15'd1;

  typedef enum logic [1:0] {
    CMD_POLL  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2
  } kmes_cmd_e;

  typedef enum logic [1:0] {
    CFG_REPEAT_DELAY    = 2'd0,
    CFG_REPEAT_PERIOD   = 2'd1,
    CFG_SENSE_MASK_LOW  = 2'd2,
    CFG_SENSE_MASK_HIGH = 2'd3
  } kmes_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPEAT,
    ST_POP,
    ST_QUERY,
    ST_DONE
  } kmes_state_e;

  // one queued event, key code in the lowest bits
  typedef struct packed {
    logic             repeat_ev;
    logic             key_up;
    logic             ctrl;
    logic             shift;
    logic [KEY_W-1:0] key;
  } kmes_event_t;

  // bits read at the probe address of the snapshot store
  typedef struct packed {
    logic sensed;
    logic prev;
    logic now;
  } kmes_probe_t;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic             pad;
    logic [KEY_W-1:0] query_key;
    logic [55:0]      matrix_high;
    logic [63:0]      matrix_low;
  } kmes_in_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [3:0]          pad;
    logic [QCOUNT_W-1:0] queue_count;
    logic                key_released;
    logic                key_pressed;
    logic                key_held;
    logic                event_repeat;
    logic                event_key_up;
    logic                event_ctrl;
    logic                event_shift;
    logic [KEY_W-1:0]    event_key;
    logic                event_valid;
  } kmes_result_t;

endpackage

// ----- design/kmes_event_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmes_event_fifo: event queue of the key matrix event scanner
// Circular buffer holding DEPTH-1 events; pushes into a full queue drop.
// ----------------------------------------------------------------------------
module kmes_event_fifo #(
  parameter int DEPTH = kmes_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  kmes_pkg::kmes_event_t          push_data_i,
  input  logic                           pop_i,
  output kmes_pkg::kmes_event_t          rd_data_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH)-1:0]       count_o
);
  import kmes_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  kmes_event_t        mem [DEPTH];
  kmes_event_t        rd_data_q;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]   wr_next, rd_next;
  logic [PTR_W:0]     wrap_sum;
  logic               full;

  assign wr_next  = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next  = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign full     = (wr_next == rd_ptr_q);
  assign empty_o  = (wr_ptr_q == rd_ptr_q);
  assign wrap_sum = {1'b0, wr_ptr_q} + (PTR_W + 1)'(DEPTH) - {1'b0, rd_ptr_q};
  assign count_o  = (wr_ptr_q >= rd_ptr_q) ? wr_ptr_q - rd_ptr_q : wrap_sum[PTR_W-1:0];
  assign rd_data_o = rd_data_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i && !full) begin
      wr_ptr_d = wr_next;
    end
    if (pop_i && !empty_o) begin
      rd_ptr_d = rd_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (push_i && !full) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty event queue");

  a_no_push_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && pop_i))
    else $error("push and pop in one cycle");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full |=> $stable(wr_ptr_q))
    else $error("push into full queue moved the write pointer");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |=> count_o == PTR_W'($past(count_o) - 1'b1))
    else $error("pop did not lower the event count by one");
`endif

endmodule

// ----- design/kmes_snapshot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmes_snapshot: current and previous key matrix snapshots
// Loads a new matrix on poll and serves one probe address per cycle.
// ----------------------------------------------------------------------------
module kmes_snapshot #(
  parameter int ROW_COUNT = kmes_pkg::ROW_COUNT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [63:0]                           matrix_low_i,
  input  logic [55:0]                           matrix_high_i,
  input  logic [kmes_pkg::MATRIX_BITS-1:0]      sense_mask_i,
  input  logic [kmes_pkg::KEY_W-1:0]            probe_code_i,
  output kmes_pkg::kmes_probe_t                 probe_o,
  output logic                                  shift_o,
  output logic                                  ctrl_o
);
  import kmes_pkg::*;

  localparam int ROW_BITS = 8 * ROW_COUNT;
  localparam int IDX_W    = $clog2(ROW_BITS);

  logic [ROW_BITS-1:0]    current_q, previous_q, load_rows;
  logic [MATRIX_BITS-1:0] matrix;
  logic [IDX_W-1:0]       idx;
  logic                   in_rows, in_mask;

  assign matrix = {matrix_high_i, matrix_low_i};

  // rows beyond the matrix ports read as not held
  if (ROW_BITS <= MATRIX_BITS) begin : g_trim
    assign load_rows = matrix[ROW_BITS-1:0];
  end else begin : g_pad
    assign load_rows = {{(ROW_BITS - MATRIX_BITS){1'b0}}, matrix};
  end

  if (ROW_BITS > SHIFT_CODE) begin : g_shift
    assign shift_o = current_q[SHIFT_CODE];
  end else begin : g_no_shift
    assign shift_o = 1'b0;
  end

  if (ROW_BITS > CTRL_CODE) begin : g_ctrl
    assign ctrl_o = current_q[CTRL_CODE];
  end else begin : g_no_ctrl
    assign ctrl_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_q  <= '0;
      previous_q <= '0;
    end else if (load_i) begin
      previous_q <= current_q;
      current_q  <= load_rows;
    end
  end

  assign idx     = probe_code_i[IDX_W-1:0];
  assign in_rows = ({1'b0, probe_code_i} < 8'(ROW_BITS));
  assign in_mask = ({1'b0, probe_code_i} < 8'(MATRIX_BITS));

  always_comb begin
    probe_o        = '0;
    probe_o.now    = in_rows && current_q[idx];
    probe_o.prev   = in_rows && previous_q[idx];
    probe_o.sensed = in_mask && sense_mask_i[probe_code_i];
  end

endmodule

// ----- design/key_matrix_event_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_event_scanner: key matrix scanner with typematic repeat
// Turns matrix snapshots into queued press, release and repeat events.
// ----------------------------------------------------------------------------
// Poll: one scan code per cycle in SCAN, then REPEAT and DONE. Pop and query
//   pass through POP or QUERY to DONE; empty pop and command 3 go to DONE.
// Each returns to IDLE from DONE, where tready is high again.
// One transaction in work at a time; the output register holds a result until
//   taken, and a new result waits in DONE while it is held, with tready low.
// Reset clears snapshots, queue pointers, repeat state and the output;
//   registers return to delay 12, period 1 and all keys sensed.
// ----------------------------------------------------------------------------
module key_matrix_event_scanner #(
  parameter int QUEUE_DEPTH = kmes_pkg::QUEUE_DEPTH_DEF,
  parameter int ROW_COUNT   = kmes_pkg::ROW_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: matrix_low[63:0], matrix_high[119:64], query_key[126:120]
  input  logic [kmes_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]                        s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: event_valid[0], event_key[7:1], event_shift[8], event_ctrl[9],
  //        event_key_up[10], event_repeat[11], key_held[12], key_pressed[13],
  //        key_released[14], queue_count[19:15]
  output logic [kmes_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [kmes_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import kmes_pkg::*;

  localparam int ROW_BITS   = 8 * ROW_COUNT;
  localparam int SCAN_CODES = (ROW_BITS < MATRIX_BITS) ? ROW_BITS : MATRIX_BITS;
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);

  // configuration registers
  logic [DELAY_W-1:0]     delay_q, period_q;
  logic [MATRIX_BITS-1:0] mask_q;

  // sequencer state
  kmes_state_e            state_q, state_d;
  logic [KEY_W-1:0]       code_q, code_d;
  logic [KEY_W-1:0]       qkey_q, qkey_d;
  logic [KEY_W-1:0]       rkey_q, rkey_d;
  logic signed [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  kmes_result_t           res_q, res_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  kmes_result_t           out_data_q, out_data_d;

  // datapath links
  kmes_in_t               in_item;
  kmes_cmd_e              in_cmd;
  logic                   load;
  logic [KEY_W-1:0]       probe_code;
  kmes_probe_t            probe;
  logic                   shift, ctrl;
  logic                   fifo_push, fifo_pop, fifo_empty;
  kmes_event_t            push_ev, pop_ev;
  logic [PTR_W-1:0]       fifo_count;
  logic                   accept, out_load;

  assign in_item       = kmes_in_t'(s_axis_tdata);
  assign in_cmd        = kmes_cmd_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cnt_inc       = cnt_q + 16'sd1;

  // --------------------------------------------------------------------------
  // Configuration: a zero repeat value falls back to its default
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DEFAULT_DELAY;
      period_q <= DEFAULT_PERIOD;
      mask_q   <= '1;
    end else if (cfg_valid_i) begin
      unique case (kmes_cfg_e'(cfg_index_i))
        CFG_REPEAT_DELAY: begin
          delay_q <= (cfg_data_i[DELAY_W-1:0] != '0) ? cfg_data_i[DELAY_W-1:0]
                                                     : DEFAULT_DELAY;
        end
        CFG_REPEAT_PERIOD: begin
          period_q <= (cfg_data_i[DELAY_W-1:0] != '0) ? cfg_data_i[DELAY_W-1:0]
                                                      : DEFAULT_PERIOD;
        end
        CFG_SENSE_MASK_LOW:  mask_q[63:0]   <= cfg_data_i;
        CFG_SENSE_MASK_HIGH: mask_q[119:64] <= cfg_data_i[55:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Snapshot store and event queue
  // --------------------------------------------------------------------------
  kmes_snapshot #(
    .ROW_COUNT (ROW_COUNT)
  ) u_snapshot (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .matrix_low_i  (in_item.matrix_low),
    .matrix_high_i (in_item.matrix_high),
    .sense_mask_i  (mask_q),
    .probe_code_i  (probe_code),
    .probe_o       (probe),
    .shift_o       (shift),
    .ctrl_o        (ctrl)
  );

  kmes_event_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_event_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (push_ev),
    .pop_i       (fifo_pop),
    .rd_data_o   (pop_ev),
    .empty_o     (fifo_empty),
    .count_o     (fifo_count)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  //   IDLE   take a transaction and dispatch on its command
  //   SCAN   one scan code per cycle: queue edges, arm repeat on fresh press
  //   REPEAT advance the typematic counter of the repeating key
  //   POP    read data of the queue is ready
  //   QUERY  probe the asked key
  //   DONE   hand the result to the output register once it is free
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    qkey_d      = qkey_q;
    rkey_d      = rkey_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    load        = 1'b0;
    fifo_push   = 1'b0;
    fifo_pop    = 1'b0;
    push_ev     = '0;
    push_ev.shift = shift;
    push_ev.ctrl  = ctrl;
    probe_code  = code_q;
    out_load    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d  = '0;
          qkey_d = in_item.query_key;
          unique case (in_cmd)
            CMD_POLL: begin
              load    = 1'b1;
              code_d  = '0;
              state_d = ST_SCAN;
            end
            CMD_POP: begin
              if (!fifo_empty) begin
                fifo_pop = 1'b1;
                state_d  = ST_POP;
              end else begin
                state_d = ST_DONE;
              end
            end
            CMD_QUERY: state_d = ST_QUERY;
            default:   state_d = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        probe_code = code_q;
        if (probe.sensed && (probe.now != probe.prev)) begin
          fifo_push      = 1'b1;
          push_ev.key    = code_q;
          push_ev.key_up = probe.prev;
          // a fresh press takes over the repeat
          if (probe.now && (rkey_q != code_q)) begin
            rkey_d = code_q;
            cnt_d  = 16'sd0 - $signed({1'b0, delay_q});
          end
        end
        if (code_q == KEY_W'(SCAN_CODES - 1)) begin
          state_d = ST_REPEAT;
        end else begin
          code_d = code_q + 1'b1;
        end
      end

      ST_REPEAT: begin
        probe_code = rkey_q;
        if (rkey_q != NO_KEY) begin
          if (probe.now) begin
            if (cnt_inc >= $signed({1'b0, period_q})) begin
              cnt_d             = '0;
              fifo_push         = 1'b1;
              push_ev.key       = rkey_q;
              push_ev.repeat_ev = 1'b1;
            end else begin
              cnt_d = cnt_inc;
            end
          end else begin
            // key let go: stop repeating
            rkey_d = NO_KEY;
          end
        end
        state_d = ST_DONE;
      end

      ST_POP: begin
        res_d.event_valid  = 1'b1;
        res_d.event_key    = pop_ev.key;
        res_d.event_shift  = pop_ev.shift;
        res_d.event_ctrl   = pop_ev.ctrl;
        res_d.event_key_up = pop_ev.key_up;
        res_d.event_repeat = pop_ev.repeat_ev;
        state_d            = ST_DONE;
      end

      ST_QUERY: begin
        probe_code         = qkey_q;
        res_d.key_held     = probe.now;
        res_d.key_pressed  = probe.now && !probe.prev;
        res_d.key_released = probe.prev && !probe.now;
        state_d            = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      code_q  <= '0;
      rkey_q  <= NO_KEY;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      rkey_q  <= rkey_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qkey_q <= qkey_d;
    res_q  <= res_d;
  end

  // --------------------------------------------------------------------------
  // Output register: hold the result until the sink takes it
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d            = 1'b1;
      out_data_d             = res_q;
      out_data_d.queue_count = QCOUNT_W'(fifo_count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

`ifndef SYNTHESIS
  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> {1'b0, code_q} < 8'(SCAN_CODES))
    else $error("scan code beyond the scanned range");

  a_rkey_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rkey_q == NO_KEY || {1'b0, rkey_q} < 8'(SCAN_CODES))
    else $error("repeating key outside the scanned range");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("second transaction taken while one is in work");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !out_load)
    else $error("pending result overwritten");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the key matrix event scanner
// Drives polls, pops, queries and the unused command through the input
// stream. Predicts every result with a cycle-free model of snapshots, event
// queue and typematic repeat, and checks each result in order. The run goes
// through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import kmes_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         HOLD_CYCLES = 400;

  // --------------------------------------------------------------------------
  // Event and snapshot model with the store of results still owed by the block
  // --------------------------------------------------------------------------
  class keyscan_model;
    logic [7:0]       now_rows  [ROW_COUNT_DEF];
    logic [7:0]       prev_rows [ROW_COUNT_DEF];
    kmes_event_t      event_fifo [$];
    logic [KEY_W-1:0] rpt_key;
    int               rpt_count;
    int unsigned      rpt_delay;
    int unsigned      rpt_period;
    logic [63:0]      sense_lo;
    logic [55:0]      sense_hi;
    kmes_result_t     pending_results [$];
    int               mismatches;
    int               commands_seen;
    int               results_seen;
    int               events_popped;
    int               repeats_popped;
    int               pushes_dropped;

    function new();
      foreach (now_rows[r]) begin
        now_rows[r]  = '0;
        prev_rows[r] = '0;
      end
      rpt_key        = NO_KEY;
      rpt_count      = 0;
      rpt_delay      = DEFAULT_DELAY;
      rpt_period     = DEFAULT_PERIOD;
      sense_lo       = '1;
      sense_hi       = '1;
      mismatches     = 0;
      commands_seen  = 0;
      results_seen   = 0;
      events_popped  = 0;
      repeats_popped = 0;
      pushes_dropped = 0;
    endfunction

    // codes beyond the last row read as released in both snapshots
    function bit key_state(bit from_prev, int code);
      int row;
      row = code >> 3;
      if (row >= ROW_COUNT_DEF) return 1'b0;
      return from_prev ? prev_rows[row][code % 8] : now_rows[row][code % 8];
    endfunction

    function bit is_sensed(int code);
      if (code < 64) return sense_lo[code];
      return sense_hi[code - 64];
    endfunction

    // drop the event when only one slot is left
    function void queue_event(int code, bit is_repeat, bit is_up);
      kmes_event_t ev;
      if (event_fifo.size() >= QUEUE_DEPTH_DEF - 1) begin
        pushes_dropped++;
        return;
      end
      ev.key       = code[KEY_W-1:0];
      ev.shift     = key_state(1'b0, SHIFT_CODE);
      ev.ctrl      = key_state(1'b0, CTRL_CODE);
      ev.key_up    = is_up;
      ev.repeat_ev = !is_up && is_repeat;
      event_fifo.push_back(ev);
    endfunction

    function void scan_poll(logic [63:0] lo, logic [55:0] hi);
      bit now_b;
      bit prev_b;
      prev_rows = now_rows;
      for (int r = 0; r < ROW_COUNT_DEF; r++) begin
        if (r < 8) now_rows[r] = lo[8*r +: 8];
        else       now_rows[r] = hi[8*(r-8) +: 8];
      end
      for (int code = 0; code < 8 * ROW_COUNT_DEF; code++) begin
        if (!is_sensed(code)) continue;
        now_b  = key_state(1'b0, code);
        prev_b = key_state(1'b1, code);
        if (now_b == prev_b) continue;
        queue_event(code, 1'b0, prev_b && !now_b);
        if (now_b && rpt_key != code) begin
          rpt_key   = code[KEY_W-1:0];
          rpt_count = -int'(rpt_delay);
        end
      end
      // advance typematic repeat once per poll, stop it on release
      if (rpt_key != NO_KEY) begin
        if (key_state(1'b0, rpt_key)) begin
          rpt_count++;
          if (rpt_count >= int'(rpt_period)) begin
            rpt_count = 0;
            queue_event(rpt_key, 1'b1, 1'b0);
          end
        end else begin
          rpt_key = NO_KEY;
        end
      end
    endfunction

    function void write_register(kmes_cfg_e idx, logic [63:0] value);
      case (idx)
        CFG_REPEAT_DELAY:    rpt_delay  = (value[14:0] != 0) ? value[14:0] : DEFAULT_DELAY;
        CFG_REPEAT_PERIOD:   rpt_period = (value[14:0] != 0) ? value[14:0] : DEFAULT_PERIOD;
        CFG_SENSE_MASK_LOW:  sense_lo   = value;
        CFG_SENSE_MASK_HIGH: sense_hi   = value[55:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [1:0] cmd, logic [63:0] lo, logic [55:0] hi,
                               logic [KEY_W-1:0] qkey);
      kmes_result_t res;
      kmes_event_t  ev;
      res = '0;
      commands_seen++;
      case (cmd)
        CMD_POLL: scan_poll(lo, hi);
        CMD_POP: begin
          if (event_fifo.size() != 0) begin
            ev               = event_fifo.pop_front();
            res.event_valid  = 1'b1;
            res.event_key    = ev.key;
            res.event_shift  = ev.shift;
            res.event_ctrl   = ev.ctrl;
            res.event_key_up = ev.key_up;
            res.event_repeat = ev.repeat_ev;
            events_popped++;
            if (ev.repeat_ev) repeats_popped++;
          end
        end
        CMD_QUERY: begin
          res.key_held     = key_state(1'b0, qkey);
          res.key_pressed  = key_state(1'b0, qkey) && !key_state(1'b1, qkey);
          res.key_released = !key_state(1'b0, qkey) && key_state(1'b1, qkey);
        end
        default: ;
      endcase
      res.queue_count = QCOUNT_W'(event_fifo.size());
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(kmes_result_t got);
      kmes_result_t want;
      if (pending_results.size() == 0) begin
        $error("result %h arrived with no command outstanding", got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      compare_field("event_valid",  want.event_valid,  got.event_valid);
      compare_field("event_key",    want.event_key,    got.event_key);
      compare_field("event_shift",  want.event_shift,  got.event_shift);
      compare_field("event_ctrl",   want.event_ctrl,   got.event_ctrl);
      compare_field("event_key_up", want.event_key_up, got.event_key_up);
      compare_field("event_repeat", want.event_repeat, got.event_repeat);
      compare_field("key_held",     want.key_held,     got.key_held);
      compare_field("key_pressed",  want.key_pressed,  got.key_pressed);
      compare_field("key_released", want.key_released, got.key_released);
      compare_field("queue_count",  want.queue_count,  got.queue_count);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = CMD_POLL;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i   = CFG_REPEAT_DELAY;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  keyscan_model model = new();

  // matrix the sender presents on the next poll
  logic [119:0] held_keys = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  always #10 clk_i = ~clk_i;

  key_matrix_event_scanner i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off on request so that the
  // output register stays full and the block has to stall its input
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // check each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) model.check_result(m_axis_tdata);
  end

  // watchdog: a hung handshake or a missing result ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, model.pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one command and hold it until the block takes it; note it on
  // acceptance. Called just after a rising edge.
  task automatic send_item(logic [1:0] cmd, logic [63:0] lo, logic [55:0] hi,
                           logic [KEY_W-1:0] qkey);
    kmes_in_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    item.pad         = 1'b0;
    item.query_key   = qkey;
    item.matrix_high = hi;
    item.matrix_low  = lo;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    model.note_command(cmd, lo, hi, qkey);
  endtask

  task automatic send_poll();
    send_item(CMD_POLL, held_keys[63:0], held_keys[119:64],
              KEY_W'($urandom_range(127)));
  endtask

  task automatic write_reg(kmes_cfg_e idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.write_register(idx, value);
  endtask

  // write all four registers back to back, then drop the valid
  task automatic load_registers(logic [63:0] delay_v, logic [63:0] period_v,
                                logic [63:0] mask_lo_v, logic [63:0] mask_hi_v);
    write_reg(CFG_REPEAT_DELAY,    delay_v);
    write_reg(CFG_REPEAT_PERIOD,   period_v);
    write_reg(CFG_SENSE_MASK_LOW,  mask_lo_v);
    write_reg(CFG_SENSE_MASK_HIGH, mask_hi_v);
    cfg_valid_i <= 1'b0;
  endtask

  // Drain every owed result and let the block return to idle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Favour a handful of keys and the modifiers so that presses, releases and
  // holds long enough for repeat all happen often
  function automatic int pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(15);
    if (r < 70) return SHIFT_CODE + $urandom_range(1);
    return $urandom_range(119);
  endfunction

  task automatic next_matrix();
    logic [127:0] wide;
    int           r;
    r = $urandom_range(99);
    if (r < 8) begin
      wide      = {$urandom, $urandom, $urandom, $urandom};
      held_keys = wide[119:0];
    end else if (r < 14) begin
      held_keys = '0;
    end else if (r >= 30) begin
      held_keys[pick_code()] ^= 1'b1;
      if ($urandom_range(99) < 30) held_keys[pick_code()] ^= 1'b1;
    end
    // otherwise keep the matrix as is and let repeat tick
  endtask

  task automatic random_items(int count);
    logic [127:0] noise;
    int           pick;
    int           qkey;
    for (int i = 0; i < count; i++) begin
      pick  = $urandom_range(99);
      noise = {$urandom, $urandom, $urandom, $urandom};
      qkey  = ($urandom_range(1) != 0) ? pick_code() : $urandom_range(127);
      if (pick < 40) begin
        next_matrix();
        send_item(CMD_POLL, held_keys[63:0], held_keys[119:64], KEY_W'(qkey));
      end else if (pick < 80) begin
        send_item(CMD_POP, noise[63:0], noise[119:64], KEY_W'(qkey));
      end else if (pick < 95) begin
        send_item(CMD_QUERY, noise[63:0], noise[119:64], KEY_W'(qkey));
      end else begin
        send_item(CMD_UNUSED, noise[63:0], noise[119:64], KEY_W'(qkey));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset registers: empty queue, unused command,
    // every key at once (fills the queue and drops the rest), unmapped
    // query codes, release of everything, and modifiers with a key.
    send_item(CMD_QUERY, '0, '0, 7'd0);
    send_item(CMD_POP, '0, '0, 7'd0);
    send_item(CMD_UNUSED, '1, '1, 7'd127);
    held_keys = '1;
    send_poll();
    send_item(CMD_QUERY, '0, '0, 7'(SHIFT_CODE));
    send_item(CMD_QUERY, '0, '0, 7'd127);
    send_item(CMD_QUERY, '0, '0, 7'd120);
    send_item(CMD_QUERY, '0, '0, 7'd119);
    send_item(CMD_POP, '1, '1, 7'd0);
    send_item(CMD_POP, '0, '0, 7'd0);
    held_keys = '0;
    send_poll();
    send_item(CMD_QUERY, '0, '0, 7'd0);
    send_item(CMD_POP, '0, '0, 7'd0);
    held_keys[7]          = 1'b1;
    held_keys[SHIFT_CODE] = 1'b1;
    held_keys[CTRL_CODE]  = 1'b1;
    send_poll();
    send_poll();
    send_item(CMD_QUERY, '0, '0, 7'(CTRL_CODE));
    send_item(CMD_QUERY, '0, '0, 7'd7);
    send_item(CMD_POP, '0, '0, 7'd0);

    // back to back on both sides
    random_items(150);
    drain_results();

    // short delay, everything sensed; sender mostly idle
    load_registers(64'd2, 64'd1, '1, '1);
    send_idle_pct = 81;
    random_items(150);
    drain_results();

    // junk above the 15-bit delay field, random masks; receiver mostly
    // stalled, starting with a long hold-off while the sender keeps offering
    load_registers({49'h1_2345_6789_ABCD, 15'd3}, 64'd3,
                   {$urandom, $urandom}, {$urandom, $urandom});
    send_idle_pct = 0;
    stall_pct     = 81;
    hold_req++;
    random_items(150);
    drain_results();

    // shortest delay, zero period (takes the default), only high codes sensed
    load_registers(64'd1, 64'd0, '0, '1);
    send_idle_pct = 25;
    stall_pct     = 25;
    random_items(150);
    drain_results();

    // longest delay and period with high codes off, then zero delay (takes the default)
    load_registers(64'd32767, 64'd32767, '1, '0);
    send_idle_pct = 0;
    stall_pct     = 0;
    random_items(40);
    drain_results();
    load_registers(64'd0, 64'd2, '1, '1);
    random_items(30);

    drain_results();
    repeat (200) @(posedge clk_i);

    $display("Ran %0d commands and checked %0d results over six register settings",
             model.commands_seen, model.results_seen);
    $display("Popped %0d events (%0d repeats); %0d pushes hit a full queue",
             model.events_popped, model.repeats_popped, model.pushes_dropped);
    if (model.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
